// ===== design/pcg32_bounded_random_defines.svh =====
// Assertion macros for the bounded random generator.
// Both sample on the rising edge of clk and are switched off while rst is high.
`ifndef PCG32_BOUNDED_RANDOM_DEFINES_SVH
`define PCG32_BOUNDED_RANDOM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pcg32br_pkg.sv =====
package pcg32br_pkg;

  // Request beat: inclusive lower bound and exclusive upper bound.
  typedef struct packed {
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
  } req_t;

  // Response beat: the drawn value.
  typedef struct packed {
    logic signed [31:0] random_value;
  } rsp_t;

endpackage

// ===== design/pcg32br_if.sv =====
// Request channel.
interface pcg32br_req_if;
  logic                valid;
  logic                ready;
  pcg32br_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Response channel.
interface pcg32br_rsp_if;
  logic                valid;
  logic                ready;
  pcg32br_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/pcg32_bounded_random.sv =====
// Bounded random number generator built on a 64-bit LCG with an XSH-RR output.
// A request beat on req carries range_min and range_max; one response beat on rsp
// returns range_min + (draw mod span), with span = range_max - range_min mod 2^32.
// Equal bounds return range_min at once and leave the generator untouched.
// The block takes one request at a time: req.ready is high only while it is idle.
// With equal bounds the request goes from entry straight to hand-off.
// Otherwise the divider first computes the rejection limit, then each draw runs
// three 32x32 partial products on one shared multiplier, the increment add and
// the output mix, and the accepted draw goes through the same one-bit-per-cycle
// divider before hand-off. Each rejected draw adds another generator step.
// req.ready rises in the same cycle as rsp.valid.
// The response sits in an output register, so a new request is taken while a
// stalled response waits; the block only holds a finished result when that
// register is still full.
// cfg_we with cfg_wdata loads the seed into the generator state; write it only
// while the block is idle. Reset clears the generator state to zero and empties
// the output register.
`include "pcg32_bounded_random_defines.svh"

module pcg32_bounded_random (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [63:0]          cfg_wdata,
  pcg32br_req_if.sink          req,
  pcg32br_rsp_if.source        rsp
);

  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC = 64'd11634580027462260723;
  localparam int unsigned XS_SHIFT_A = 18;
  localparam int unsigned XS_SHIFT_B = 27;
  localparam int unsigned ROT_SHIFT  = 59;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_MUL0   = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_MUL3   = 4'd5;
  localparam logic [3:0] S_ADV    = 4'd6;
  localparam logic [3:0] S_DRAW   = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [31:0] range_lo;
  logic [31:0] range_hi;
  logic [31:0] span;
  logic [31:0] cutoff;
  logic [63:0] gen_state;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [4:0]  cnt;
  logic        div_cut;
  logic [31:0] res;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  logic [31:0] rem_step;
  logic [63:0] mix_word;
  logic [31:0] mixed;
  logic [4:0]  rot;
  logic [63:0] rot_pair;
  logic [31:0] draw;
  logic        out_free;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  // Shared multiplier operands: low x low, low x high, high x low.
  assign mul_a = (state == S_MUL2) ? gen_state[63:32] : gen_state[31:0];
  assign mul_b = (state == S_MUL1) ? LCG_MUL[63:32] : LCG_MUL[31:0];

  // One restoring division step.
  assign rem_sh   = {rem, dvd[31]};
  assign rem_diff = rem_sh - {1'b0, span};
  assign rem_step = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];

  // XSH-RR output of the current generator state.
  assign mix_word = (gen_state >> XS_SHIFT_A) ^ gen_state;
  assign mixed    = mix_word[XS_SHIFT_B +: 32];
  assign rot      = gen_state[ROT_SHIFT +: 5];
  assign rot_pair = {mixed, mixed} >> rot;
  assign draw     = rot_pair[31:0];

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req.valid) state_next = S_START;
      S_START:  state_next = (range_lo == range_hi) ? S_RESULT : S_DIV;
      S_MUL0:   state_next = S_MUL1;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_MUL3;
      S_MUL3:   state_next = S_ADV;
      S_ADV:    state_next = S_DRAW;
      S_DRAW:   state_next = (draw <= cutoff) ? S_DIV : S_MUL0;
      S_DIV: begin
        if (cnt == 5'd31) state_next = div_cut ? S_MUL0 : S_RESULT;
      end
      S_RESULT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      gen_state <= '0;
    end else begin
      state <= state_next;
      prod  <= mul_a * mul_b;

      // The response register fills from a finished result and empties when its
      // beat is taken.
      if (state == S_RESULT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            range_lo <= req.data.range_min;
            range_hi <= req.data.range_max;
          end
        end
        S_START: begin
          span <= range_hi - range_lo;
          res  <= range_lo;
          // Rejection limit comes from 0xFFFFFFFF mod span.
          rem     <= '0;
          dvd     <= '1;
          cnt     <= '0;
          div_cut <= 1'b1;
        end
        S_MUL1: acc <= prod;
        S_MUL2: acc[63:32] <= acc[63:32] + prod[31:0];
        S_MUL3: acc[63:32] <= acc[63:32] + prod[31:0];
        S_DRAW: begin
          rem     <= '0;
          dvd     <= draw;
          cnt     <= '0;
          div_cut <= 1'b0;
        end
        S_DIV: begin
          rem <= rem_step;
          dvd <= dvd << 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            if (div_cut) cutoff <= ~rem_step;
            else res <= range_lo + rem_step;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            rsp.data.random_value <= res;
          end
        end
        default: ;
      endcase

      // A seed write reloads the generator; the user must write only while idle,
      // which the block does not enforce. Otherwise the generator steps on its own.
      if (cfg_we) gen_state <= cfg_wdata;
      else if (state == S_ADV) gen_state <= acc + LCG_INC;
    end
  end

  // The generator moves only on its own step or a seed write.
  `PCG_ASSERT_NEXT(a_state_hold, !cfg_we && state != S_ADV, $stable(gen_state),
                   "generator state changed outside a step")
  // The partial remainder stays below the divisor during division.
  `PCG_ASSERT_NOW(a_rem_bound, state == S_DIV, rem < span,
                  "divider remainder not below span")
  // A rejected draw starts a fresh generator step.
  `PCG_ASSERT_NEXT(a_reject_retry, state == S_DRAW && draw > cutoff, state == S_MUL0,
                   "rejected draw did not retry")
  // A finished result moves into a free output register at once.
  `PCG_ASSERT_NEXT(a_result_out, state == S_RESULT && out_free,
                   rsp.valid && state == S_IDLE, "result not handed to output")

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // LCG step and XSH-RR output mix.
  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC = 64'd11634580027462260723;
  localparam int unsigned XS_SHIFT_A = 18;
  localparam int unsigned XS_SHIFT_B = 27;
  localparam int unsigned ROT_SHIFT = 59;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  pcg32br_req_if req_ch ();
  pcg32br_rsp_if rsp_ch ();

  pcg32_bounded_random DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Predictor state: the seed register and the generator it loads.
  logic [63:0] seed_reg;
  logic [63:0] gen_state;

  // Values still owed by the block, oldest first.
  logic [31:0] expected_values[$];

  int          mismatches = 0;
  int          cycle_count = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;

  always #5 clk = ~clk;

  // One 32-bit output from a freshly stepped generator state.
  function automatic logic [31:0] pcg_output(input logic [63:0] s);
    logic [63:0] folded;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] doubled;
    folded = ((s >> XS_SHIFT_A) ^ s) >> XS_SHIFT_B;
    mixed = folded[31:0];
    rot = s[ROT_SHIFT +: 5];
    doubled = {mixed, mixed} >> rot;
    return doubled[31:0];
  endfunction

  // Bounded draw with rejection; advances gen_state once per draw.
  function automatic logic [31:0] draw_bounded(input logic [31:0] lo, input logic [31:0] hi);
    logic [31:0] span;
    logic [31:0] cutoff;
    logic [31:0] draw;
    if (lo == hi) begin
      return lo;
    end
    span = hi - lo;
    cutoff = ALL_ONES32 - (ALL_ONES32 % span);
    do begin
      gen_state = gen_state * LCG_MUL + LCG_INC;
      draw = pcg_output(gen_state);
    end while (draw > cutoff);
    return lo + (draw % span);
  endfunction

  // Offer one request beat, after an optional gap, and predict its value once taken.
  // The valid stays high on return so that a following beat can go out back to back.
  task automatic request_draw(input logic [31:0] lo, input logic [31:0] hi);
    pcg32br_pkg::req_t beat;
    int unsigned       roll;
    int unsigned       gap;
    logic [31:0]       owed;
    gap = 0;
    if (tx_gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.range_min = lo;
    beat.range_max = hi;
    req_ch.valid <= 1'b1;
    req_ch.data <= beat;
    do @(posedge clk); while (!req_ch.ready);
    owed = draw_bounded(lo, hi);
    expected_values.insert(expected_values.size(), owed);
  endtask

  // Stop offering and wait until every owed value has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Seed write, only with the block idle.
  task automatic load_seed(input logic [63:0] s);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    seed_reg = s;
    gen_state = s;
  endtask

  // The generator runs from the zero reset state when nobody seeded it.
  task automatic test_unseeded_start();
    request_draw(32'd0, 32'd10);
    request_draw(-32'sd5, 32'sd5);
    request_draw(32'h5555_5555, 32'hAAAA_AAAA);
    wait_drained();
  endtask

  // Seeds at both ends of the range.
  task automatic test_seed_extremes();
    load_seed(64'hFFFF_FFFF_FFFF_FFFF);
    request_draw(32'd0, 32'd1000);
    request_draw(INT_MIN, INT_MAX);
    load_seed(64'd0);
    request_draw(32'd0, 32'd1000);
    request_draw(32'hFFFF_FF00, 32'h0000_0100);
    wait_drained();
  endtask

  // Equal bounds, reversed bounds, span of one, the full span and spans that reject often.
  task automatic test_bound_corners();
    request_draw(32'd0, 32'd0);
    request_draw(INT_MIN, INT_MIN);
    request_draw(INT_MAX, INT_MAX);
    request_draw(INT_MIN, INT_MAX);
    request_draw(INT_MAX, INT_MIN);
    request_draw(32'd0, 32'd1);
    request_draw(32'sd5, -32'sd5);
    request_draw(32'd0, INT_MIN);
    request_draw(32'd0, 32'h8000_0001);
    request_draw(INT_MAX, 32'h7FFF_FFFE);
    request_draw(32'd1, 32'd4);
    wait_drained();
  endtask

  // The response side holds off long enough for the block to fill and refuse requests.
  task automatic test_input_stall();
    tx_gaps_on = 1'b0;
    hold_len = 400;
    hold_seq++;
    repeat (2) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      request_draw($urandom, $urandom);
    end
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  // Random requests, weighted toward narrow spans and spans just past half the range.
  task automatic test_random_draws(input int count);
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned kind;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      lo = $urandom;
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          hi = lo;
        end
        1, 2, 3, 4: begin
          hi = lo + $urandom_range(1, 1000);
        end
        5: begin
          hi = lo - $urandom_range(1, 1000);
        end
        6: begin
          hi = lo + INT_MIN + $urandom_range(0, 1000);
        end
        default: begin
          hi = $urandom;
        end
      endcase
      request_draw(lo, hi);
    end
    wait_drained();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Response ready: random stalls, calm stretches, and the long hold on request.
  always @(posedge clk) begin : drive_rsp_ready
    int unsigned roll;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      stall_left = hold_len;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!rx_stalls_on) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        stall_left = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
      end
    end
  end

  // Each response beat against the oldest owed value.
  always @(posedge clk) begin : check_rsp
    logic [31:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_values.size() == 0) begin
        $error("random_value: no request pending, actual %0d",
               $signed(rsp_ch.data.random_value));
        mismatches++;
      end else begin
        want = expected_values.pop_front();
        if (rsp_ch.data.random_value !== want) begin
          $error("random_value: expected %0d, actual %0d", $signed(want),
                 $signed(rsp_ch.data.random_value));
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    seed_reg = '0;
    gen_state = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unseeded_start();
    test_seed_extremes();
    test_bound_corners();
    test_input_stall();
    test_random_draws(170);
    for (int p = 0; p < 3; p++) begin
      load_seed({$urandom, $urandom});
      test_random_draws(170);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pcg32br_pkg.sv
design/pcg32br_if.sv
design/pcg32_bounded_random.sv
bench/tb.sv
